// ===== sv/crs_pkg.sv =====
// crs_pkg: shared types, codes and constants for the chunk relay sender
// no dependencies
`default_nettype none
package crs_pkg;
  localparam int MAX_FRAGMENTS_DEF = 16;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_READY = 2'd1;
  localparam logic [1:0] CMD_ACK   = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_REQ   = 2'd1;
  localparam logic [1:0] KIND_FRAG  = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BUSY      = 2'd1;
  localparam logic [1:0] ST_SIZE      = 2'd2;
  localparam logic [1:0] ST_SRC       = 2'd3;
  localparam logic [1:0] END_DONE     = 2'd0;
  localparam logic [1:0] END_FIRST    = 2'd1;
  localparam logic [1:0] END_READ     = 2'd2;
  localparam logic [1:0] END_TIMEOUT  = 2'd3;

  localparam logic [1:0] REG_CPB    = 2'd0;
  localparam logic [1:0] REG_WINDOW = 2'd1;
  localparam logic [1:0] REG_RESEND = 2'd2;
  localparam logic [1:0] REG_MAXATT = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [47:0] peer_address;
    logic [23:0] image_size;
    logic        source_ok;
    logic [15:0] acked_chunk;
    logic [12:0] payload_length;
    logic [4:0]  fragment_count;
    logic [31:0] now_us;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  status;
    logic [15:0] chunk_total;
    logic [15:0] chunk_number;
    logic [3:0]  fragment_number;
    logic [47:0] dest_address;
    logic        last;
  } out_item_t;
endpackage
`default_nettype wire

// ===== sv/chunk_relay_arq_sender.sv =====
// chunk_relay_arq_sender: stop-and-wait chunk sender, top level
// depends on crs_pkg, crs_front, crs_engine, crs_divider
// start, chunk-ready with a burst and a tick that resends a burst wait on the
// 32-step shared divider; other commands go straight to their result beat, or back
// to idle when they give no result
// throughput: one command at a time in the engine, two-entry input queue
// synchronous active-low reset returns registers and session state to defaults
`default_nettype none
module chunk_relay_arq_sender #(
  parameter int MAX_FRAGMENTS = crs_pkg::MAX_FRAGMENTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire crs_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output crs_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  logic [12:0] cpb_r;
  logic [31:0] win_r;
  logic [15:0] rsd_r;
  logic [7:0]  att_r;
  logic q_valid, q_pop, busy;
  crs_pkg::in_item_t q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpb_r <= 13'd200; win_r <= 32'd20000; rsd_r <= 16'd500; att_r <= 8'd5;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        crs_pkg::REG_CPB:    cpb_r <= cfg_data[12:0];
        crs_pkg::REG_WINDOW: win_r <= cfg_data;
        crs_pkg::REG_RESEND: rsd_r <= cfg_data[15:0];
        crs_pkg::REG_MAXATT: att_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  crs_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  crs_engine #(.MAX_FRAGMENTS(MAX_FRAGMENTS)) u_engine (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .chunk_payload_bytes(cpb_r), .send_window_us(win_r),
    .resend_interval_ms(rsd_r), .max_attempts(att_r), .busy(busy),
    .out_valid(out_valid), .out_stall(out_stall && busy || out_stall),
    .out_data(out_data)
  );
endmodule
`default_nettype wire

// ===== sv/crs_divider.sv =====
// crs_divider: radix-2 restoring divider, one quotient bit per cycle
// depends on nothing
`default_nettype none
module crs_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [31:0]      quotient
);
  logic [5:0]  cnt_r;
  logic [31:0] q_r, rem_r, dvs_r;
  logic [32:0] trial;

  assign trial = {rem_r, q_r[31]} - {1'b0, dvs_r};
  assign busy = (cnt_r != 6'd0);
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 6'd0;
    end else if (start) begin
      cnt_r <= 6'd32;
      q_r <= dividend;
      rem_r <= 32'd0;
      dvs_r <= divisor;
    end else if (busy) begin
      cnt_r <= cnt_r - 6'd1;
      if (!trial[32]) begin
        rem_r <= trial[31:0];
        q_r <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= {rem_r[30:0], q_r[31]};
        q_r <= {q_r[30:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/crs_front.sv =====
// crs_front: input queue between the accepting side and the session engine
// depends on crs_pkg
`default_nettype none
module crs_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire crs_pkg::in_item_t in_data,
  output logic                   q_valid,
  input  wire logic              q_pop,
  output crs_pkg::in_item_t      q_data
);
  crs_pkg::in_item_t buf_r [2];
  logic [1:0] cnt_r;
  logic       rd_r, wr_r;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = buf_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      if (push) begin
        wr_r <= !wr_r;
      end
      if (q_pop) begin
        rd_r <= !rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_r] <= in_data;
    end
  end
endmodule
`default_nettype wire

// ===== sv/crs_engine.sv =====
// crs_engine: session state machine, runs one queued command at a time
// depends on crs_pkg and crs_divider
`default_nettype none
module crs_engine #(
  parameter int MAX_FRAGMENTS = crs_pkg::MAX_FRAGMENTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire crs_pkg::in_item_t q_data,
  input  wire logic [12:0]       chunk_payload_bytes,
  input  wire logic [31:0]       send_window_us,
  input  wire logic [15:0]       resend_interval_ms,
  input  wire logic [7:0]        max_attempts,
  output logic                   busy,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output crs_pkg::out_item_t     out_data
);
  localparam int FW = $clog2(MAX_FRAGMENTS + 1) > 5 ? $clog2(MAX_FRAGMENTS + 1) : 5;
  localparam logic [FW-1:0] MAXF = FW'(MAX_FRAGMENTS);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_DIVCNT, S_DIVINT, S_OUT1, S_OUT2
  } state_t;

  state_t state_r;
  logic        active_r, await_r, adv_r, wait_r;
  logic [47:0] target_r;
  logic [15:0] cur_r, total_r;
  logic [7:0]  att_r;
  logic [FW-1:0] burst_r, sent_r;
  logic [31:0] intv_r, due_r, lastms_r;
  crs_pkg::in_item_t cmd_r;
  crs_pkg::out_item_t o1_r, o2_r;
  logic        dstart;
  logic [31:0] dend, dvs, dq;
  logic        dbusy;
  logic        out_take;

  logic [12:0] cpb;
  logic [FW-1:0] fc_sat;
  logic [31:0] ms_el;
  logic [31:0] us_el;
  logic [15:0] nxt_chunk;

  assign cpb = (chunk_payload_bytes == 13'd0) ? 13'd1 : chunk_payload_bytes;
  assign fc_sat = (FW'(cmd_r.fragment_count) > MAXF) ? MAXF : FW'(cmd_r.fragment_count);
  assign ms_el = cmd_r.now_ms - lastms_r;
  assign us_el = cmd_r.now_us - due_r;
  assign nxt_chunk = cur_r + 16'd1;
  assign out_take = out_valid && !out_stall;
  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign busy = (state_r != S_IDLE) || q_valid;

  crs_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .dividend(dend), .divisor(dvs),
    .busy(dbusy), .quotient(dq)
  );

  function automatic crs_pkg::out_item_t mk(logic [1:0] k, logic [1:0] s,
      logic [15:0] t, logic [15:0] c, logic [3:0] f, logic [47:0] d, logic l);
    crs_pkg::out_item_t r;
    r.result_kind = k; r.status = s; r.chunk_total = t; r.chunk_number = c;
    r.fragment_number = f; r.dest_address = d; r.last = l;
    return r;
  endfunction

  always_comb begin
    dstart = 1'b0;
    dend = 32'd0;
    dvs = 32'd1;
    if (state_r == S_EXEC) begin
      if (cmd_r.command == crs_pkg::CMD_START) begin
        dstart = !active_r && cmd_r.image_size != 24'd0 && cmd_r.source_ok;
        dend = 32'(cmd_r.image_size) + 32'(cpb) - 32'd1;
        dvs = 32'(cpb);
      end else if (cmd_r.command == crs_pkg::CMD_READY) begin
        dstart = active_r && wait_r && cmd_r.payload_length != 13'd0 && fc_sat != '0;
        dend = send_window_us;
        dvs = 32'(fc_sat);
      end else if (cmd_r.command == crs_pkg::CMD_TICK) begin
        dstart = active_r && !wait_r && !(sent_r < burst_r) && !adv_r && await_r &&
                 ms_el >= 32'(resend_interval_ms) && att_r < max_attempts &&
                 burst_r != '0;
        dend = send_window_us;
        dvs = 32'(burst_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      active_r <= 1'b0; await_r <= 1'b0; adv_r <= 1'b0; wait_r <= 1'b0;
      target_r <= 48'd0; cur_r <= 16'd0; total_r <= 16'd0; att_r <= 8'd0;
      burst_r <= '0; sent_r <= '0; intv_r <= 32'd0; due_r <= 32'd0;
      lastms_r <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_data;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_IDLE;
          case (cmd_r.command)
            crs_pkg::CMD_START: begin
              if (active_r) begin
                o1_r <= mk(crs_pkg::KIND_REPLY, crs_pkg::ST_BUSY, 16'd0, 16'd0, 4'd0,
                           cmd_r.peer_address, 1'b1);
                state_r <= S_OUT2;
              end else if (cmd_r.image_size == 24'd0) begin
                o1_r <= mk(crs_pkg::KIND_REPLY, crs_pkg::ST_SIZE, 16'd0, 16'd0, 4'd0,
                           cmd_r.peer_address, 1'b1);
                state_r <= S_OUT2;
              end else if (!cmd_r.source_ok) begin
                o1_r <= mk(crs_pkg::KIND_REPLY, crs_pkg::ST_SRC, 16'd0, 16'd0, 4'd0,
                           cmd_r.peer_address, 1'b1);
                state_r <= S_OUT2;
              end else begin
                active_r <= 1'b1; target_r <= cmd_r.peer_address; cur_r <= 16'd0;
                await_r <= 1'b0; adv_r <= 1'b0; att_r <= 8'd0;
                burst_r <= '0; sent_r <= '0; wait_r <= 1'b1;
                state_r <= S_DIVCNT;
              end
            end
            crs_pkg::CMD_READY: begin
              if (active_r && wait_r) begin
                wait_r <= 1'b0;
                if (cmd_r.payload_length == 13'd0) begin
                  o1_r <= mk(crs_pkg::KIND_END,
                             (cur_r == 16'd0) ? crs_pkg::END_FIRST : crs_pkg::END_READ,
                             16'd0, cur_r, 4'd0, target_r, 1'b1);
                  active_r <= 1'b0; await_r <= 1'b0; adv_r <= 1'b0;
                  sent_r <= '0; burst_r <= '0;
                  state_r <= S_OUT2;
                end else begin
                  burst_r <= fc_sat; sent_r <= '0; due_r <= cmd_r.now_us;
                  await_r <= 1'b1; lastms_r <= cmd_r.now_ms;
                  if (att_r != 8'hFF) att_r <= att_r + 8'd1;
                  if (fc_sat == '0) intv_r <= 32'd0;
                  else state_r <= S_DIVINT;
                end
              end
            end
            crs_pkg::CMD_ACK: begin
              if (active_r && !wait_r && cmd_r.peer_address == target_r &&
                  cmd_r.acked_chunk == cur_r) begin
                await_r <= 1'b0; adv_r <= 1'b1;
              end
            end
            default: begin
              if (active_r && !wait_r) begin
                if (sent_r < burst_r) begin
                  if (!us_el[31]) begin
                    o1_r <= mk(crs_pkg::KIND_FRAG, crs_pkg::ST_OK, 16'd0, cur_r,
                               sent_r[3:0], target_r, 1'b1);
                    sent_r <= sent_r + FW'(1);
                    due_r <= due_r + intv_r;
                    state_r <= S_OUT2;
                  end
                end else if (adv_r) begin
                  adv_r <= 1'b0; cur_r <= nxt_chunk; att_r <= 8'd0;
                  state_r <= S_OUT2;
                  if (nxt_chunk >= total_r) begin
                    o1_r <= mk(crs_pkg::KIND_END, crs_pkg::END_DONE, 16'd0, nxt_chunk,
                               4'd0, target_r, 1'b1);
                    active_r <= 1'b0; await_r <= 1'b0; wait_r <= 1'b0;
                    sent_r <= '0; burst_r <= '0;
                  end else begin
                    wait_r <= 1'b1;
                    o1_r <= mk(crs_pkg::KIND_REQ, crs_pkg::ST_OK, 16'd0, nxt_chunk,
                               4'd0, target_r, 1'b1);
                  end
                end else if (await_r && ms_el >= 32'(resend_interval_ms)) begin
                  if (att_r >= max_attempts) begin
                    o1_r <= mk(crs_pkg::KIND_END, crs_pkg::END_TIMEOUT, 16'd0, cur_r,
                               4'd0, target_r, 1'b1);
                    active_r <= 1'b0; await_r <= 1'b0; adv_r <= 1'b0; wait_r <= 1'b0;
                    sent_r <= '0; burst_r <= '0;
                    state_r <= S_OUT2;
                  end else begin
                    sent_r <= '0; due_r <= cmd_r.now_us; await_r <= 1'b1;
                    lastms_r <= cmd_r.now_ms;
                    if (att_r != 8'hFF) att_r <= att_r + 8'd1;
                    if (burst_r == '0) intv_r <= 32'd0;
                    else state_r <= S_DIVINT;
                  end
                end
              end
            end
          endcase
        end
        S_DIVCNT: begin
          if (!dbusy && !dstart) begin
            total_r <= dq[15:0];
            o1_r <= mk(crs_pkg::KIND_REPLY, crs_pkg::ST_OK, dq[15:0], 16'd0, 4'd0,
                       target_r, 1'b0);
            o2_r <= mk(crs_pkg::KIND_REQ, crs_pkg::ST_OK, 16'd0, 16'd0, 4'd0,
                       target_r, 1'b1);
            out_valid <= 1'b1;
            state_r <= S_OUT1;
          end
        end
        S_DIVINT: begin
          if (!dbusy) begin
            intv_r <= dq;
            state_r <= S_IDLE;
          end
        end
        S_OUT1: begin
          if (out_take) begin
            o1_r <= o2_r;
            state_r <= S_OUT2;
          end
        end
        S_OUT2: begin
          // raise valid if it is not already up, then wait for the beat to go
          if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (out_take) begin
            out_valid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_OUT1 && out_take) out_valid <= 1'b1;
    end
  end

  assign out_data = o1_r;
endmodule
`default_nettype wire

// ===== tb/chunk_relay_arq_sender_test.sv =====
// chunk_relay_arq_sender_test: self-checking bench for the stop-and-wait chunk sender
// depends on crs_pkg and chunk_relay_arq_sender; predicts every result beat in-line
`default_nettype none
module chunk_relay_arq_sender_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W = $bits(crs_pkg::in_item_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  crs_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  crs_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  chunk_relay_arq_sender uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [12:0] cpb_reg;
  logic [31:0] window_reg;
  logic [15:0] resend_reg;
  logic [7:0] maxatt_reg;
  logic sess, awaiting, adv_pend, want_chunk;
  logic [47:0] target;
  logic [15:0] cur_chunk, tot_chunks;
  logic [7:0] attempts;
  logic [4:0] burst_n, sent_n;
  logic [31:0] frag_gap, due_us, sent_ms;

  crs_pkg::out_item_t expected_beats[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int hold_cycles = 0;
  bit rand_stall = 1'b1;
  logic [47:0] peer_pool[4];
  logic [31:0] clk_us, clk_ms;

  function automatic crs_pkg::out_item_t mk(logic [1:0] k, logic [1:0] s, logic [15:0] tot,
                                            logic [15:0] ch, logic [3:0] fr,
                                            logic [47:0] d, logic l);
    crs_pkg::out_item_t r;
    r.result_kind = k; r.status = s; r.chunk_total = tot; r.chunk_number = ch;
    r.fragment_number = fr; r.dest_address = d; r.last = l;
    return r;
  endfunction

  task automatic close_session();
    sess = 0; awaiting = 0; adv_pend = 0; want_chunk = 0; sent_n = '0; burst_n = '0;
  endtask

  task automatic arm(logic [31:0] us, logic [31:0] ms);
    sent_n = '0;
    frag_gap = (burst_n != '0) ? window_reg / 32'(burst_n) : 32'd0;
    due_us = us;
    awaiting = 1;
    sent_ms = ms;
    if (attempts < 8'd255) attempts++;
  endtask

  task automatic predict_sender(crs_pkg::in_item_t it);
    logic [31:0] cpb;
    logic [31:0] d;
    case (it.command)
      crs_pkg::CMD_START: begin
        if (sess)
          expected_beats.push_back(mk(crs_pkg::KIND_REPLY, crs_pkg::ST_BUSY, '0, '0, '0,
                                      it.peer_address, 1'b1));
        else if (it.image_size == '0)
          expected_beats.push_back(mk(crs_pkg::KIND_REPLY, crs_pkg::ST_SIZE, '0, '0, '0,
                                      it.peer_address, 1'b1));
        else if (!it.source_ok)
          expected_beats.push_back(mk(crs_pkg::KIND_REPLY, crs_pkg::ST_SRC, '0, '0, '0,
                                      it.peer_address, 1'b1));
        else begin
          cpb = (cpb_reg != '0) ? 32'(cpb_reg) : 32'd1;
          sess = 1; target = it.peer_address; cur_chunk = '0;
          tot_chunks = 16'((32'(it.image_size) + cpb - 32'd1) / cpb);
          awaiting = 0; adv_pend = 0; attempts = '0; burst_n = '0; sent_n = '0;
          want_chunk = 1;
          expected_beats.push_back(mk(crs_pkg::KIND_REPLY, crs_pkg::ST_OK, tot_chunks, '0,
                                      '0, it.peer_address, 1'b0));
          expected_beats.push_back(mk(crs_pkg::KIND_REQ, crs_pkg::ST_OK, '0, '0, '0,
                                      target, 1'b1));
        end
      end
      crs_pkg::CMD_READY: begin
        if (sess && want_chunk) begin
          want_chunk = 0;
          if (it.payload_length == '0) begin
            expected_beats.push_back(mk(crs_pkg::KIND_END,
                                        (cur_chunk == '0) ? crs_pkg::END_FIRST
                                                          : crs_pkg::END_READ,
                                        '0, cur_chunk, '0, target, 1'b1));
            close_session();
          end else begin
            burst_n = (it.fragment_count > 5'(crs_pkg::MAX_FRAGMENTS_DEF))
                      ? 5'(crs_pkg::MAX_FRAGMENTS_DEF) : it.fragment_count;
            arm(it.now_us, it.now_ms);
          end
        end
      end
      crs_pkg::CMD_ACK: begin
        if (sess && !want_chunk && it.peer_address == target &&
            it.acked_chunk == cur_chunk) begin
          awaiting = 0; adv_pend = 1;
        end
      end
      default: begin
        if (sess && !want_chunk) begin
          d = it.now_us - due_us;
          if (sent_n < burst_n) begin
            if (!d[31]) begin
              expected_beats.push_back(mk(crs_pkg::KIND_FRAG, crs_pkg::ST_OK, '0, cur_chunk,
                                          sent_n[3:0], target, 1'b1));
              sent_n++;
              due_us += frag_gap;
            end
          end else if (adv_pend) begin
            adv_pend = 0; cur_chunk++; attempts = '0;
            if (cur_chunk >= tot_chunks) begin
              expected_beats.push_back(mk(crs_pkg::KIND_END, crs_pkg::END_DONE, '0,
                                          cur_chunk, '0, target, 1'b1));
              close_session();
            end else begin
              want_chunk = 1;
              expected_beats.push_back(mk(crs_pkg::KIND_REQ, crs_pkg::ST_OK, '0, cur_chunk,
                                          '0, target, 1'b1));
            end
          end else if (awaiting && (it.now_ms - sent_ms) >= 32'(resend_reg)) begin
            if (attempts >= maxatt_reg) begin
              expected_beats.push_back(mk(crs_pkg::KIND_END, crs_pkg::END_TIMEOUT, '0,
                                          cur_chunk, '0, target, 1'b1));
              close_session();
            end else arm(it.now_us, it.now_ms);
          end
        end
      end
    endcase
  endtask

  // valid stays up after an accepted beat until the next gap or a drain
  task automatic send_item(crs_pkg::in_item_t it);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 18)) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_sender(it);
    n_items++;
  endtask

  // result checker with random stall
  always @(posedge clk) begin
    crs_pkg::out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat %p", out_data);
        errors++;
      end else begin
        exp_r = expected_beats.pop_front();
        if (out_data.result_kind !== exp_r.result_kind) begin
          $error("result_kind exp %0d got %0d", exp_r.result_kind, out_data.result_kind);
          errors++;
        end
        if (out_data.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, out_data.status); errors++;
        end
        if (out_data.chunk_total !== exp_r.chunk_total) begin
          $error("chunk_total exp %0d got %0d", exp_r.chunk_total, out_data.chunk_total);
          errors++;
        end
        if (out_data.chunk_number !== exp_r.chunk_number) begin
          $error("chunk_number exp %0d got %0d", exp_r.chunk_number, out_data.chunk_number);
          errors++;
        end
        if (out_data.fragment_number !== exp_r.fragment_number) begin
          $error("fragment_number exp %0d got %0d", exp_r.fragment_number,
                 out_data.fragment_number);
          errors++;
        end
        if (out_data.dest_address !== exp_r.dest_address) begin
          $error("dest_address exp %h got %h", exp_r.dest_address, out_data.dest_address);
          errors++;
        end
        if (out_data.last !== exp_r.last) begin
          $error("last exp %0d got %0d", exp_r.last, out_data.last); errors++;
        end
      end
    end
  end

  // receiver stall: long hold-off when requested, else random per beat, or none when random stall is off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (!rand_stall) out_stall <= 1'b0;
    else if (out_stall) out_stall <= ($urandom_range(0, 18) != 0) && ($urandom_range(0, 2) == 0);
    else if (out_valid) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= 1'b0;
  end

  task automatic drain(int extra);
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      crs_pkg::REG_CPB: cpb_reg = v[12:0];
      crs_pkg::REG_WINDOW: window_reg = v;
      crs_pkg::REG_RESEND: resend_reg = v[15:0];
      crs_pkg::REG_MAXATT: maxatt_reg = v[7:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [31:0] c, logic [31:0] w, logic [31:0] r, logic [31:0] m);
    drain(60);
    write_reg(crs_pkg::REG_CPB, c); write_reg(crs_pkg::REG_WINDOW, w);
    write_reg(crs_pkg::REG_RESEND, r); write_reg(crs_pkg::REG_MAXATT, m);
    cfg_valid <= 1'b0;
  endtask

  function automatic crs_pkg::in_item_t noise_item();
    crs_pkg::in_item_t it;
    it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.payload_length = 13'($urandom_range(0, 8191));
    return it;
  endfunction

  function automatic crs_pkg::in_item_t cmd_item(logic [1:0] c, logic [47:0] p,
                                                 logic [23:0] sz, logic ok,
                                                 logic [15:0] ack, logic [12:0] pl,
                                                 logic [4:0] fc);
    crs_pkg::in_item_t it;
    it = noise_item();
    it.command = c; it.peer_address = p; it.image_size = sz; it.source_ok = ok;
    it.acked_chunk = ack; it.payload_length = pl; it.fragment_count = fc;
    it.now_us = clk_us; it.now_ms = clk_ms;
    return it;
  endfunction

  task automatic advance_time(int us_step, int ms_step);
    clk_us += 32'(us_step); clk_ms += 32'(ms_step);
  endtask

  // one well-formed session with random loss, bad acks and timing
  task automatic run_session(int max_chunks);
    logic [47:0] p;
    logic [47:0] ack_p;
    logic [15:0] ack_c;
    logic [12:0] pl;
    logic [4:0] fc;
    int steps;
    p = peer_pool[$urandom_range(0, 3)];
    send_item(cmd_item(crs_pkg::CMD_START, p, 24'($urandom_range(1, 200 * max_chunks)),
                       1'b1, '0, '0, '0));
    steps = 0;
    while (sess && steps < 400) begin
      steps++;
      advance_time($urandom_range(0, 3000), $urandom_range(0, 150));
      if (want_chunk) begin
        pl = ($urandom_range(0, 40) == 0) ? 13'd0 : 13'($urandom_range(1, 4096));
        fc = 5'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6));
        send_item(cmd_item(crs_pkg::CMD_READY, p, '0, 1'b0, '0, pl, fc));
      end else if (sent_n >= burst_n && awaiting && $urandom_range(0, 2) == 0) begin
        ack_p = ($urandom_range(0, 7) == 0) ? peer_pool[$urandom_range(0, 3)] : p;
        ack_c = ($urandom_range(0, 7) == 0) ? 16'($urandom) : cur_chunk;
        send_item(cmd_item(crs_pkg::CMD_ACK, ack_p, '0, 1'b0, ack_c, '0, '0));
      end else if ($urandom_range(0, 15) == 0) send_item(noise_item());
      else send_item(cmd_item(crs_pkg::CMD_TICK, p, '0, 1'b0, '0, '0, '0));
    end
  endtask

  task automatic test_rejects();
    send_item(cmd_item(crs_pkg::CMD_START, '1, '0, 1'b1, '0, '0, '0));
    send_item(cmd_item(crs_pkg::CMD_START, '0, 24'hFFFFFF, 1'b0, '0, '0, '0));
    send_item(cmd_item(crs_pkg::CMD_READY, 48'h1, '0, 1'b0, '0, 13'd100, 5'd3));
    send_item(cmd_item(crs_pkg::CMD_ACK, 48'h1, '0, 1'b0, '0, '0, '0));
    send_item(cmd_item(crs_pkg::CMD_TICK, 48'h1, '0, 1'b0, '0, '0, '0));
  endtask

  task automatic test_directed_session();
    logic [47:0] p;
    p = 48'hFFFF_FFFF_FFFF;
    // two chunks at the default chunk size, with a busy start and an empty-chunk end
    send_item(cmd_item(crs_pkg::CMD_START, p, 24'd300, 1'b1, '0, '0, '0));
    send_item(cmd_item(crs_pkg::CMD_START, 48'h5, 24'd1, 1'b1, '0, '0, '0));
    send_item(cmd_item(crs_pkg::CMD_READY, p, '0, 1'b0, '0, 13'd4096, 5'd31));
    repeat (17) begin
      advance_time(1250, 1);
      send_item(cmd_item(crs_pkg::CMD_TICK, p, '0, 1'b0, '0, '0, '0));
    end
    send_item(cmd_item(crs_pkg::CMD_ACK, 48'h7, '0, 1'b0, '0, '0, '0));
    send_item(cmd_item(crs_pkg::CMD_ACK, p, '0, 1'b0, 16'hFFFF, '0, '0));
    send_item(cmd_item(crs_pkg::CMD_ACK, p, '0, 1'b0, '0, '0, '0));
    send_item(cmd_item(crs_pkg::CMD_TICK, p, '0, 1'b0, '0, '0, '0));
    send_item(cmd_item(crs_pkg::CMD_READY, p, '0, 1'b0, '0, 13'd0, 5'd0));
    // first chunk read failure
    send_item(cmd_item(crs_pkg::CMD_START, 48'h0, 24'd1, 1'b1, '0, '0, '0));
    send_item(cmd_item(crs_pkg::CMD_READY, 48'h0, '0, 1'b0, '0, 13'd0, 5'd1));
  endtask

  task automatic test_timeouts();
    // zero fragments, then resends until attempts run out
    send_item(cmd_item(crs_pkg::CMD_START, 48'hA, 24'd10, 1'b1, '0, '0, '0));
    send_item(cmd_item(crs_pkg::CMD_READY, 48'hA, '0, 1'b0, '0, 13'd10, 5'd0));
    repeat (8) begin
      advance_time(10, 600);
      send_item(cmd_item(crs_pkg::CMD_TICK, 48'hA, '0, 1'b0, '0, '0, '0));
    end
  endtask

  task automatic test_random(int n);
    int target_n;
    target_n = n_items + n;
    while (n_items < target_n) begin
      if ($urandom_range(0, 9) == 0) send_item(noise_item());
      else run_session(($urandom_range(0, 5) == 0) ? 12 : 3);
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 600;
    test_random(30);
  endtask

  initial begin
    cpb_reg = 13'd200; window_reg = 32'd20000; resend_reg = 16'd500; maxatt_reg = 8'd5;
    target = '0; cur_chunk = '0; tot_chunks = '0; attempts = '0;
    frag_gap = '0; due_us = '0; sent_ms = '0;
    close_session();
    clk_us = 32'hFFFF_F000; clk_ms = 32'hFFFF_FF00;
    peer_pool = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'h1234_5678_9ABC, 48'hA5A5_5A5A_0F0F};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_rejects();
    test_directed_session();
    test_timeouts();
    set_regs(32'd0, 32'd0, 32'd0, 32'd0);
    test_timeouts();
    test_random(150);
    set_regs(32'd4096, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'd255);
    test_random(100);
    set_regs(32'd1, 32'd40, 32'd1, 32'd1);
    test_directed_session();
    test_random(300);
    set_regs(32'h1FFF, 32'd16000, 32'd50, 32'd3);
    test_backpressure();
    rand_stall = 1'b0;
    test_random(150);
    rand_stall = 1'b1;
    set_regs(32'd200, 32'd20000, 32'd100, 32'd5);
    test_random(450);
    drain(60);
    $display("covered %0d input items and %0d result beats over several register settings,",
             n_items, n_results);
    $display("including rejects, timeouts, read failures, bad acks and a long receiver hold-off");
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
